[rtl/core/mm64_pkg.sv]
// ----------------------------------------------------------------------------
// MurmurHash64A stream hasher package
// Shared constants, the queued item type and the multiplier handshake types.
// ----------------------------------------------------------------------------
package mm64_pkg;

    localparam logic [63:0] MIX_MULT    = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT   = 47;
    localparam int          QUEUE_DEPTH = 2;

    // How the back end folds one item into the running hash.
    typedef enum logic [1:0] {
        K_NONE,
        K_TAIL,
        K_FULL
    } t_kind;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic [63:0] word;
        t_kind       kind;
        logic        first;
        logic        last;
        logic [31:0] length;
    } t_item;

    // Request to and response from the shared multiply-by-M unit.
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_mul_rsp;

endpackage

[rtl/core/mm64_front.sv]
// ----------------------------------------------------------------------------
// MurmurHash64A front end
// Accepts input requests, masks unused bytes, classifies each item and
// pushes it into the queue.
// ----------------------------------------------------------------------------
module mm64_front
    import mm64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_item,
    input  logic [31:0] i_message_length,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    // High while a message has started and its last item is not yet taken.
    logic r_in_msg;
    logic n_in_msg;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            o_item.word[j*8 +: 8] = (i_byte_count > 4'(j)) ? i_data_word[j*8 +: 8] : 8'h00;
        end
        if (i_byte_count[3]) begin
            o_item.kind = K_FULL;
        end else if (i_byte_count == 4'd0) begin
            o_item.kind = K_NONE;
        end else begin
            o_item.kind = K_TAIL;
        end
        o_item.first  = !r_in_msg;
        o_item.last   = i_last_item;
        o_item.length = i_message_length;
        n_in_msg      = o_push ? !i_last_item : r_in_msg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else begin
            r_in_msg <= n_in_msg;
        end
    end

endmodule

[rtl/core/mm64_queue.sv]
// ----------------------------------------------------------------------------
// MurmurHash64A item queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module mm64_queue
    import mm64_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty,
    output logic  o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/core/mm64_mul.sv]
// ----------------------------------------------------------------------------
// MurmurHash64A multiply unit
// Forms operand * M modulo 2^64 on one 32x32 multiplier over four steps.
// ----------------------------------------------------------------------------
module mm64_mul
    import mm64_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    // Low 32x32 product, then the two cross products that land in the top half.
    typedef enum logic [1:0] {
        ST_LO_LO,
        ST_HI_LO,
        ST_LO_HI,
        ST_SUM
    } t_step;

    t_step       r_step;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_a;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod;

    always_comb begin
        case (r_step)
            ST_HI_LO: begin
                op_x = r_a[63:32];
                op_y = MIX_MULT[31:0];
            end
            ST_LO_HI: begin
                op_x = r_a[31:0];
                op_y = MIX_MULT[63:32];
            end
            default: begin
                op_x = r_a[31:0];
                op_y = MIX_MULT[31:0];
            end
        endcase
        prod = 64'(op_x) * 64'(op_y);
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.operand;
        end
        if (r_busy) begin
            r_prod <= prod;
            case (r_step)
                ST_HI_LO: r_acc <= r_prod;
                ST_LO_HI: r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                ST_SUM:   r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                default:  r_acc <= r_acc;
            endcase
        end
        if (!i_rst_n) begin
            r_step <= ST_LO_LO;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_step <= ST_LO_LO;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                case (r_step)
                    ST_LO_LO: r_step <= ST_HI_LO;
                    ST_HI_LO: r_step <= ST_LO_HI;
                    ST_LO_HI: r_step <= ST_SUM;
                    default: begin
                        r_step <= ST_LO_LO;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

[rtl/core/mm64_back.sv]
// ----------------------------------------------------------------------------
// MurmurHash64A back end
// Sequences the seeding, word scramble, hash fold and finalization of each
// message item by item and holds the result for the output channel.
// ----------------------------------------------------------------------------
module mm64_back
    import mm64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_seed,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_pop,
    output t_mul_req    o_mul_req,
    input  t_mul_rsp    i_mul_rsp,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_BODY,
        S_K1,
        S_K2,
        S_HMUL,
        S_CHECK,
        S_FIN
    } t_state;

    t_state      r_state;
    t_state      n_state;
    t_item       r_item;
    t_item       n_item;
    logic [63:0] r_h;
    logic [63:0] n_h;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [63:0] r_out;
    logic [63:0] n_out;

    // Set once the finalize product has landed in r_h.
    logic r_h_ready;

    always_comb begin
        logic [63:0] v_res;
        v_res       = i_mul_rsp.result;
        n_state     = r_state;
        n_item      = r_item;
        n_h         = r_h;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        o_mul_req   = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop  = 1'b1;
                    n_item = i_q_item;
                    if (i_q_item.first) begin
                        o_mul_req.start   = 1'b1;
                        o_mul_req.operand = {32'h0, i_q_item.length};
                        n_state           = S_SEED;
                    end else begin
                        n_state = S_BODY;
                    end
                end
            end
            S_SEED: begin
                if (i_mul_rsp.done) begin
                    n_h     = i_seed ^ v_res;
                    n_state = S_BODY;
                end
            end
            S_BODY: begin
                case (r_item.kind)
                    K_FULL: begin
                        o_mul_req.start   = 1'b1;
                        o_mul_req.operand = r_item.word;
                        n_state           = S_K1;
                    end
                    K_TAIL: begin
                        o_mul_req.start   = 1'b1;
                        o_mul_req.operand = r_h ^ r_item.word;
                        n_state           = S_HMUL;
                    end
                    default: n_state = S_CHECK;
                endcase
            end
            S_K1: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = v_res ^ (v_res >> MIX_SHIFT);
                    n_state           = S_K2;
                end
            end
            S_K2: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = r_h ^ v_res;
                    n_state           = S_HMUL;
                end
            end
            S_HMUL: begin
                if (i_mul_rsp.done) begin
                    n_h     = v_res;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_item.last) begin
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = r_h ^ (r_h >> MIX_SHIFT);
                    n_state           = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                // Wait for the product, then for room in the output register.
                if (i_mul_rsp.done) begin
                    n_h = v_res;
                end
                if (r_h_ready && (!r_out_valid || !i_out_stall)) begin
                    n_out       = r_h ^ (r_h >> MIX_SHIFT);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_h    <= n_h;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_h_ready   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_FIN && i_mul_rsp.done) begin
                r_h_ready <= 1'b1;
            end else if (n_state == S_IDLE) begin
                r_h_ready <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out;

endmodule

[rtl/core/murmur64a_stream_hash.sv]
// ----------------------------------------------------------------------------
// MurmurHash64A stream hasher
// Hashes a byte message fed as little-endian 64-bit words and returns the
// 64-bit MurmurHash64A of the whole message after its last word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Request contents
//  input     in         i_in_valid / o_in_stall     data word, byte count, last, length
//  output    out        o_out_valid / i_out_stall   finalized hash value
//  config    in         i_cfg_valid / o_cfg_ready   hash seed
//
// Every multiply by M runs on one shared 32x32 multiplier. A full word takes three
// multiplies, a tail word one, a zero-byte word none, and the first word of a message
// one more for the length multiply. Finishing takes one multiply and then registers
// the result; a stalled result holds the back end once the next message reaches its
// finalization, and the two-entry queue then fills and stalls the input.
// Reset is synchronous and active low; it clears the control state and the seed to zero.
//
module murmur64a_stream_hash
    import mm64_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_item,
    input  logic [31:0] i_message_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value
);

    logic [63:0] r_seed;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_item       push_item;
    t_item       head_item;
    t_mul_req    mul_req;
    t_mul_rsp    mul_rsp;

    // The seed register takes a write request in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    mm64_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_word      (i_data_word),
        .i_byte_count     (i_byte_count),
        .i_last_item      (i_last_item),
        .i_message_length (i_message_length),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_item           (push_item)
    );

    mm64_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mm64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    mm64_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_q_empty    (q_empty),
        .i_q_item     (head_item),
        .o_pop        (pop),
        .o_mul_req    (mul_req),
        .i_mul_rsp    (mul_rsp),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

endmodule
